[hw/rtl/dcc_pkg.sv]
// ----------------------------------------------------------------------------
// dcc_pkg
// shared types, constants and lookup functions of the consensus column caller
// ----------------------------------------------------------------------------
package dcc_pkg;

  localparam int unsigned CNT_W       = 12;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned NUM_CLASSES = 6;
  localparam int unsigned PROD_W      = CFG_W + CNT_W;
  localparam int unsigned MAX_COLUMN_DEPTH_DEF = 4095;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CFG_W-1:0]  cfg_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [2:0]        cls_t;
  typedef logic [7:0]        char_t;

  // class indexes
  localparam cls_t CLS_A    = 3'd0;
  localparam cls_t CLS_C    = 3'd1;
  localparam cls_t CLS_G    = 3'd2;
  localparam cls_t CLS_T    = 3'd3;
  localparam cls_t CLS_DASH = 3'd4;
  localparam cls_t CLS_N    = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_N_TOL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DASH_TOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DEG  = 2'd2;

  localparam cfg_t N_TOL_RST    = 16'd32768;
  localparam cfg_t DASH_TOL_RST = 16'd32768;
  localparam cfg_t MIN_DEG_RST  = 16'd6554;

  // ascii codes
  localparam char_t CH_A    = 8'h41;
  localparam char_t CH_B    = 8'h42;
  localparam char_t CH_C    = 8'h43;
  localparam char_t CH_D    = 8'h44;
  localparam char_t CH_G    = 8'h47;
  localparam char_t CH_H    = 8'h48;
  localparam char_t CH_K    = 8'h4B;
  localparam char_t CH_M    = 8'h4D;
  localparam char_t CH_N    = 8'h4E;
  localparam char_t CH_R    = 8'h52;
  localparam char_t CH_S    = 8'h53;
  localparam char_t CH_T    = 8'h54;
  localparam char_t CH_V    = 8'h56;
  localparam char_t CH_W    = 8'h57;
  localparam char_t CH_Y    = 8'h59;
  localparam char_t CH_DASH = 8'h2D;
  localparam char_t CH_LA   = 8'h61;
  localparam char_t CH_LC   = 8'h63;
  localparam char_t CH_LG   = 8'h67;
  localparam char_t CH_LT   = 8'h74;

  typedef struct packed {
    cnt_t [NUM_CLASSES-1:0] counts;
    cnt_t                   total;
    logic                   ovf;
  } col_snap_t;

  typedef struct packed {
    char_t column_code;
    char_t majority_symbol;
    cnt_t  majority_count;
    cnt_t  column_length;
    logic  count_overflow;
  } col_res_t;

  function automatic cls_t class_of(char_t c);
    cls_t r;
    r = CLS_N;
    if (c == CH_A || c == CH_LA) r = CLS_A;
    if (c == CH_C || c == CH_LC) r = CLS_C;
    if (c == CH_G || c == CH_LG) r = CLS_G;
    if (c == CH_T || c == CH_LT) r = CLS_T;
    if (c == CH_DASH)            r = CLS_DASH;
    return r;
  endfunction

  function automatic char_t class_char(cls_t k);
    char_t r;
    unique case (k)
      CLS_A:    r = CH_A;
      CLS_C:    r = CH_C;
      CLS_G:    r = CH_G;
      CLS_T:    r = CH_T;
      CLS_DASH: r = CH_DASH;
      default:  r = CH_N;
    endcase
    return r;
  endfunction

  // presence bits: bit0 a, bit1 c, bit2 g, bit3 t
  function automatic char_t iupac_code(logic [3:0] p);
    char_t r;
    unique case (p)
      4'd1:    r = CH_A;
      4'd2:    r = CH_C;
      4'd3:    r = CH_M;
      4'd4:    r = CH_G;
      4'd5:    r = CH_R;
      4'd6:    r = CH_S;
      4'd7:    r = CH_V;
      4'd8:    r = CH_T;
      4'd9:    r = CH_W;
      4'd10:   r = CH_Y;
      4'd11:   r = CH_H;
      4'd12:   r = CH_K;
      4'd13:   r = CH_D;
      4'd14:   r = CH_B;
      default: r = CH_N;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/dcc_ifs.sv]
// ----------------------------------------------------------------------------
// dcc item channels
// valid/ready channels for column characters and column results
// ----------------------------------------------------------------------------
interface dcc_in_if;
  logic          valid;
  logic          ready;
  dcc_pkg::char_t symbol;
  logic          last_in_column;

  modport source (output valid, output symbol, output last_in_column, input ready);
  modport sink   (input valid, input symbol, input last_in_column, output ready);
endinterface

interface dcc_out_if;
  logic           valid;
  logic           ready;
  dcc_pkg::char_t column_code;
  dcc_pkg::char_t majority_symbol;
  dcc_pkg::cnt_t  majority_count;
  dcc_pkg::cnt_t  column_length;
  logic           count_overflow;

  modport source (output valid, output column_code, output majority_symbol,
                  output majority_count, output column_length, output count_overflow,
                  input ready);
  modport sink   (input valid, input column_code, input majority_symbol,
                  input majority_count, input column_length, input count_overflow,
                  output ready);
endinterface

[hw/rtl/degenerate_consensus_column.sv]
// a column result passes the snapshot, stage two and result registers
// throughput: one item per cycle unless held, results and items overlap freely
// the whole pipeline holds only while a result waits and the output is not ready
// reset clears the counters, the pipeline valids and loads default thresholds
// ----------------------------------------------------------------------------
// degenerate_consensus_column
// counts the characters of an alignment column and calls its iupac consensus
// ----------------------------------------------------------------------------
module degenerate_consensus_column #(
  parameter int unsigned MAX_COLUMN_DEPTH = dcc_pkg::MAX_COLUMN_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dcc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  dcc_pkg::cfg_t                       cfg_data_i,
  dcc_in_if.sink                              in_if,
  dcc_out_if.source                           out_if
);

  dcc_pkg::cfg_t      n_tol_q, dash_tol_q, min_deg_q;
  logic               adv;
  logic               snap_valid;
  dcc_pkg::col_snap_t snap;
  logic               res_valid;
  dcc_pkg::col_res_t  res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_tol_q    <= dcc_pkg::N_TOL_RST;
      dash_tol_q <= dcc_pkg::DASH_TOL_RST;
      min_deg_q  <= dcc_pkg::MIN_DEG_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dcc_pkg::CFG_N_TOL:    n_tol_q    <= cfg_data_i;
        dcc_pkg::CFG_DASH_TOL: dash_tol_q <= cfg_data_i;
        dcc_pkg::CFG_MIN_DEG:  min_deg_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign adv         = !res_valid || out_if.ready;
  assign in_if.ready = adv;

  dcc_counter #(
    .MAX_COLUMN_DEPTH (MAX_COLUMN_DEPTH)
  ) u_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .valid_i      (in_if.valid),
    .symbol_i     (in_if.symbol),
    .last_i       (in_if.last_in_column),
    .snap_valid_o (snap_valid),
    .snap_o       (snap)
  );

  dcc_call u_call (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .n_tol_i      (n_tol_q),
    .dash_tol_i   (dash_tol_q),
    .min_deg_i    (min_deg_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign out_if.valid           = res_valid;
  assign out_if.column_code     = res.column_code;
  assign out_if.majority_symbol = res.majority_symbol;
  assign out_if.majority_count  = res.majority_count;
  assign out_if.column_length   = res.column_length;
  assign out_if.count_overflow  = res.count_overflow;

`ifndef SYNTH
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid && !out_if.ready) |=> (res_valid && $stable(res)))
    else $error("stalled result changed");
`endif

endmodule

[hw/rtl/dcc_counter.sv]
// ----------------------------------------------------------------------------
// dcc_counter
// per-class saturating column counters with end-of-column snapshot
// ----------------------------------------------------------------------------
module dcc_counter #(
  parameter int unsigned MAX_COLUMN_DEPTH = dcc_pkg::MAX_COLUMN_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  dcc_pkg::char_t      symbol_i,
  input  logic                last_i,
  output logic                snap_valid_o,
  output dcc_pkg::col_snap_t  snap_o
);

  localparam int unsigned Cap = (MAX_COLUMN_DEPTH < 4095) ? MAX_COLUMN_DEPTH : 4095;
  localparam dcc_pkg::cnt_t CapVal = dcc_pkg::cnt_t'(Cap);

  dcc_pkg::cnt_t [dcc_pkg::NUM_CLASSES-1:0] counts_q, counts_d;
  dcc_pkg::cnt_t      total_q, total_d;
  logic               ovf_q, ovf_d;
  logic               acc;
  dcc_pkg::cls_t      cls;
  logic               snap_valid_q;
  dcc_pkg::col_snap_t snap_q;

  assign acc = valid_i && adv_i;
  assign cls = dcc_pkg::class_of(symbol_i);

  always_comb begin
    counts_d = counts_q;
    total_d  = total_q;
    ovf_d    = ovf_q;
    if (total_q >= CapVal) begin
      ovf_d = 1'b1;
    end else begin
      counts_d[cls] = counts_q[cls] + dcc_pkg::cnt_t'(1);
      total_d       = total_q + dcc_pkg::cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q     <= '0;
      total_q      <= '0;
      ovf_q        <= 1'b0;
      snap_valid_q <= 1'b0;
    end else if (adv_i) begin
      snap_valid_q <= acc && last_i;
      if (acc) begin
        if (last_i) begin
          counts_q <= '0;
          total_q  <= '0;
          ovf_q    <= 1'b0;
        end else begin
          counts_q <= counts_d;
          total_q  <= total_d;
          ovf_q    <= ovf_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && last_i) begin
      snap_q.counts <= counts_d;
      snap_q.total  <= total_d;
      snap_q.ovf    <= ovf_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

`ifndef SYNTH
  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CapVal)
    else $error("column total above capacity");

  a_sum_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({3'b0, counts_q[0]} + {3'b0, counts_q[1]} + {3'b0, counts_q[2]} +
     {3'b0, counts_q[3]} + {3'b0, counts_q[4]} + {3'b0, counts_q[5]}) ==
    {3'b0, total_q})
    else $error("class counts disagree with total");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (total_q == CapVal))
    else $error("overflow flagged below capacity");

  a_snap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_q |-> (snap_q.total != '0))
    else $error("empty column snapshot");
`endif

endmodule

[hw/rtl/dcc_call.sv]
// ----------------------------------------------------------------------------
// dcc_call
// two-stage base call: majority and threshold products, then code selection
// ----------------------------------------------------------------------------
module dcc_call (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               snap_valid_i,
  input  dcc_pkg::col_snap_t snap_i,
  input  dcc_pkg::cfg_t      n_tol_i,
  input  dcc_pkg::cfg_t      dash_tol_i,
  input  dcc_pkg::cfg_t      min_deg_i,
  output logic               res_valid_o,
  output dcc_pkg::col_res_t  res_o
);

  // stage one
  dcc_pkg::cls_t  best;
  dcc_pkg::cnt_t  best_cnt;
  logic [3:0]     present;

  // stage two registers
  logic           s2_valid_q;
  dcc_pkg::cls_t  s2_best_q;
  dcc_pkg::cnt_t  s2_best_cnt_q;
  dcc_pkg::cnt_t  s2_len_q;
  logic           s2_ovf_q;
  logic [3:0]     s2_present_q;
  dcc_pkg::cnt_t  s2_n_cnt_q;
  dcc_pkg::cnt_t  s2_d_cnt_q;
  dcc_pkg::prod_t s2_prod_n_q;
  dcc_pkg::prod_t s2_prod_d_q;
  dcc_pkg::prod_t s2_prod_m_q;

  // stage two logic
  logic           n_hit, d_hit, degen, keep_majority;
  dcc_pkg::cnt_t  rest;
  dcc_pkg::char_t code_base, code;

  logic              res_valid_q;
  dcc_pkg::col_res_t res_q;

  always_comb begin
    best     = dcc_pkg::CLS_A;
    best_cnt = snap_i.counts[0];
    for (int i = 1; i < dcc_pkg::NUM_CLASSES; i++) begin
      if (snap_i.counts[i] > best_cnt) begin
        best     = dcc_pkg::cls_t'(i);
        best_cnt = snap_i.counts[i];
      end
    end
    for (int j = 0; j < 4; j++) begin
      present[j] = (snap_i.counts[j] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      s2_valid_q  <= snap_valid_i;
      res_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s2_best_q     <= best;
      s2_best_cnt_q <= best_cnt;
      s2_len_q      <= snap_i.total;
      s2_ovf_q      <= snap_i.ovf;
      s2_present_q  <= present;
      s2_n_cnt_q    <= snap_i.counts[dcc_pkg::CLS_N];
      s2_d_cnt_q    <= snap_i.counts[dcc_pkg::CLS_DASH];
      s2_prod_n_q   <= {12'b0, n_tol_i} * {16'b0, snap_i.total};
      s2_prod_d_q   <= {12'b0, dash_tol_i} * {16'b0, snap_i.total};
      s2_prod_m_q   <= {12'b0, min_deg_i} * {16'b0, snap_i.total};
    end
  end

  always_comb begin
    n_hit = {s2_n_cnt_q, 16'b0} > s2_prod_n_q;
    d_hit = {s2_d_cnt_q, 16'b0} > s2_prod_d_q;
    priority if (n_hit) begin
      code_base = dcc_pkg::CH_N;
    end else if (d_hit) begin
      code_base = dcc_pkg::CH_DASH;
    end else begin
      code_base = dcc_pkg::iupac_code(s2_present_q);
    end
    degen = (code_base != dcc_pkg::CH_A) && (code_base != dcc_pkg::CH_C) &&
            (code_base != dcc_pkg::CH_G) && (code_base != dcc_pkg::CH_T) &&
            (code_base != dcc_pkg::CH_DASH);
    rest          = s2_len_q - s2_best_cnt_q;
    keep_majority = degen && ({rest, 16'b0} < s2_prod_m_q);
    code          = keep_majority ? dcc_pkg::class_char(s2_best_q) : code_base;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q.column_code     <= code;
      res_q.majority_symbol <= dcc_pkg::class_char(s2_best_q);
      res_q.majority_count  <= s2_best_cnt_q;
      res_q.column_length   <= s2_len_q;
      res_q.count_overflow  <= s2_ovf_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

`ifndef SYNTH
  a_major_le_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (res_q.majority_count <= res_q.column_length))
    else $error("majority count above column length");

  a_stage_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && s2_valid_q) |=> res_valid_q)
    else $error("result lost between stages");
`endif

endmodule
